// ===== design/quadrature_decoder_windowed_delta_macros.svh =====
// Assertion macros used by the checker of the quadrature decoder.
`ifndef QUADRATURE_DECODER_WINDOWED_DELTA_MACROS_SVH
`define QUADRATURE_DECODER_WINDOWED_DELTA_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define QDWD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quadrature decoder: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define QDWD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quadrature decoder: next-cycle check failed");

`endif

// ===== design/qdwd_pkg.sv =====
package qdwd_pkg;

	localparam int DEF_COUNT_WIDTH = 32;
	localparam int DEF_TIME_WIDTH  = 32;

	localparam int CFG_WIDTH       = 32;
	localparam int CFG_INDEX_WIDTH = 1;

	typedef logic [1:0]                 mode_t;
	typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

	localparam mode_t MODE_IDLE = 2'd0;
	localparam mode_t MODE_FWD  = 2'd1;
	localparam mode_t MODE_REV  = 2'd2;
	localparam mode_t MODE_ERR  = 2'd3;

	localparam cfg_index_t CFG_MIN_WINDOW = 1'd0;
	localparam cfg_index_t CFG_MAX_WINDOW = 1'd1;

	localparam logic [CFG_WIDTH-1:0] MIN_WINDOW_RESET = 32'd250000;
	localparam logic [CFG_WIDTH-1:0] MAX_WINDOW_RESET = 32'd500000;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] min_window_ticks;
		logic [CFG_WIDTH-1:0] max_window_ticks;
	} cfg_t;

	// Transition from the previous phase to the current one.
	function automatic mode_t move_lookup(input logic [1:0] prev, input logic [1:0] cur);
		mode_t m;
		m = MODE_ERR;
		unique case ({prev, cur})
			4'b00_00, 4'b01_01, 4'b10_10, 4'b11_11: m = MODE_IDLE;
			4'b00_10, 4'b01_00, 4'b10_11, 4'b11_01: m = MODE_FWD;
			4'b00_01, 4'b01_11, 4'b10_00, 4'b11_10: m = MODE_REV;
			default:                                m = MODE_ERR;
		endcase
		return m;
	endfunction

endpackage

// ===== design/qdwd_sample_if.sv =====
interface qdwd_sample_if #(
	parameter int TIME_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            phase;
	logic [TIME_WIDTH-1:0] timestamp;
	logic                  clear_error;

	modport source (output valid, output phase, output timestamp, output clear_error,
		input ready);
	modport sink (input valid, input phase, input timestamp, input clear_error,
		output ready);
endinterface

// ===== design/qdwd_result_if.sv =====
interface qdwd_result_if #(
	parameter int COUNT_WIDTH = 32,
	parameter int TIME_WIDTH  = 32
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    direction;
	logic signed [COUNT_WIDTH-1:0] position_count;
	logic                          window_closed;
	logic signed [COUNT_WIDTH-1:0] window_delta;
	logic [TIME_WIDTH-1:0]         window_ticks;

	modport source (output valid, output direction, output position_count,
		output window_closed, output window_delta, output window_ticks, input ready);
	modport sink (input valid, input direction, input position_count,
		input window_closed, input window_delta, input window_ticks, output ready);
endinterface

// ===== design/qdwd_in_stage.sv =====
module qdwd_in_stage
	import qdwd_pkg::*;
#(
	parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	qdwd_sample_if.sink           sample,
	input  logic                  advance,
	output logic                  valid_s1,
	output logic [1:0]            phase_s1,
	output logic [TIME_WIDTH-1:0] timestamp_s1,
	output logic                  clear_error_s1
);

	logic take;

	// Refill when empty or when the held item moves on this cycle.
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			phase_s1       <= sample.phase;
			timestamp_s1   <= sample.timestamp;
			clear_error_s1 <= sample.clear_error;
		end
	end

endmodule

// ===== design/qdwd_track.sv =====
module qdwd_track
	import qdwd_pkg::*;
#(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  valid_s1,
	input  logic [1:0]            phase_s1,
	input  logic [TIME_WIDTH-1:0] timestamp_s1,
	input  logic                  clear_error_s1,
	output logic                  advance,
	qdwd_result_if.source         result
);

	localparam int CMP_WIDTH = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

	mode_t                  mode_q;
	logic [1:0]             prev_phase_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] win_count_q;
	logic [TIME_WIDTH-1:0]  win_start_q;
	logic                   first_q;

	mode_t                  mode_look;
	logic                   clear_act;
	mode_t                  mode_n;
	logic [1:0]             prev_base;
	logic [COUNT_WIDTH-1:0] count_base;
	logic [COUNT_WIDTH-1:0] win_count_base;
	logic [TIME_WIDTH-1:0]  start_base;
	logic [COUNT_WIDTH-1:0] count_n;
	logic [TIME_WIDTH-1:0]  dt;
	logic [CMP_WIDTH-1:0]   dt_x;
	logic                   close;
	logic                   fire;

	logic                   out_valid_q;
	mode_t                  out_dir_q;
	logic [COUNT_WIDTH-1:0] out_count_q;
	logic                   out_closed_q;
	logic [COUNT_WIDTH-1:0] out_delta_q;
	logic [TIME_WIDTH-1:0]  out_ticks_q;

	assign advance = !out_valid_q || result.ready;
	assign fire    = valid_s1 && advance;

	always_comb begin
		mode_look      = (mode_q == MODE_ERR) ? MODE_ERR : move_lookup(prev_phase_q, phase_s1);
		clear_act      = (mode_look == MODE_ERR) && clear_error_s1;
		mode_n         = clear_act ? MODE_IDLE : mode_look;
		prev_base      = clear_act ? phase_s1 : prev_phase_q;
		count_base     = clear_act ? '0 : count_q;
		win_count_base = clear_act ? '0 : win_count_q;
		start_base     = clear_act ? timestamp_s1 : win_start_q;
		case (mode_n)
			MODE_FWD: count_n = count_base + COUNT_WIDTH'(1);
			MODE_REV: count_n = count_base - COUNT_WIDTH'(1);
			default:  count_n = count_base;
		endcase
		dt    = timestamp_s1 - start_base;
		dt_x  = CMP_WIDTH'(dt);
		close = (mode_n != MODE_ERR) &&
			(((dt_x >= CMP_WIDTH'(cfg.min_window_ticks)) && (phase_s1 != prev_base)) ||
			(dt_x >= CMP_WIDTH'(cfg.max_window_ticks)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			prev_phase_q <= 2'd0;
			count_q      <= '0;
			win_count_q  <= '0;
			win_start_q  <= '0;
			first_q      <= 1'b1;
		end else if (fire) begin
			if (first_q) begin
				// First sample only sets the reference phase and time.
				prev_phase_q <= phase_s1;
				win_start_q  <= timestamp_s1;
				first_q      <= 1'b0;
			end else begin
				mode_q      <= mode_n;
				count_q     <= count_n;
				win_count_q <= close ? count_n : win_count_base;
				win_start_q <= close ? timestamp_s1 : start_base;
				if (mode_n != MODE_ERR) begin
					prev_phase_q <= phase_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (first_q) begin
				out_dir_q    <= mode_q;
				out_count_q  <= count_q;
				out_closed_q <= 1'b0;
				out_delta_q  <= '0;
				out_ticks_q  <= '0;
			end else begin
				out_dir_q    <= mode_n;
				out_count_q  <= count_n;
				out_closed_q <= close;
				out_delta_q  <= close ? (count_n - win_count_base) : '0;
				out_ticks_q  <= close ? dt : '0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.direction      = out_dir_q;
	assign result.position_count = out_count_q;
	assign result.window_closed  = out_closed_q;
	assign result.window_delta   = out_delta_q;
	assign result.window_ticks   = out_ticks_q;

endmodule

// ===== design/quadrature_decoder_windowed_delta.sv =====
// Quadrature decoder (x4) with windowed count delta. Each sample transaction
// carries a two-bit encoder phase, a free-running timestamp and a clear request;
// each produces exactly one result transaction with the direction (idle, forward,
// reverse, error), the wrapping signed position count and, when a measurement
// window closes, the count change and the window length in ticks. A window
// closes once the elapsed ticks reach min_window_ticks on a phase change, or
// reach max_window_ticks regardless. A skipped phase latches the error state:
// counting and window timing hold until a sample with clear_error set arrives,
// which zeroes the count and restarts the window at that sample's own phase
// and timestamp. The very first sample after reset only captures phase and
// time. Throughput is one sample per clock while result.ready does not stall
// the output; each sample passes the input register, then the result register.
// Configuration writes (index 0 min_window_ticks, index 1 max_window_ticks)
// take effect on the next clock and are to be made while no transaction is in
// flight.
module quadrature_decoder_windowed_delta
	import qdwd_pkg::*;
#(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  cfg_index_t           wr_index,
	input  logic [CFG_WIDTH-1:0] wr_data,
	qdwd_sample_if.sink          sample,
	qdwd_result_if.source        result
);

	cfg_t                  cfg_q;

	logic                  valid_s1;
	logic [1:0]            phase_s1;
	logic [TIME_WIDTH-1:0] timestamp_s1;
	logic                  clear_error_s1;
	logic                  advance;

	// Configuration registers: write-only, applied on the write edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_window_ticks <= MIN_WINDOW_RESET;
			cfg_q.max_window_ticks <= MAX_WINDOW_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_MIN_WINDOW: cfg_q.min_window_ticks <= wr_data;
				CFG_MAX_WINDOW: cfg_q.max_window_ticks <= wr_data;
				default: ;
			endcase
		end
	end

	// Input register: holds one sample while the result side stalls.
	qdwd_in_stage #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_in_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (sample),
		.advance        (advance),
		.valid_s1       (valid_s1),
		.phase_s1       (phase_s1),
		.timestamp_s1   (timestamp_s1),
		.clear_error_s1 (clear_error_s1)
	);

	// Decode, count, window check and result register.
	qdwd_track #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.valid_s1       (valid_s1),
		.phase_s1       (phase_s1),
		.timestamp_s1   (timestamp_s1),
		.clear_error_s1 (clear_error_s1),
		.advance        (advance),
		.result         (result)
	);

endmodule

// ===== design/qdwd_checker.sv =====
`include "quadrature_decoder_windowed_delta_macros.svh"

module qdwd_checker
	import qdwd_pkg::*;
#(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [1:0]             res_direction,
	input logic [COUNT_WIDTH-1:0] res_count,
	input logic                   res_closed,
	input logic [COUNT_WIDTH-1:0] res_delta,
	input logic [TIME_WIDTH-1:0]  res_ticks
);

	// A stalled result transaction holds.
	`QDWD_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(res_count) && $stable(res_delta))

	// Window fields read zero unless a window closed.
	`QDWD_ASSERT_NOW(a_open_window_zero, res_valid && !res_closed, (res_delta == '0) && (res_ticks == '0))

	// A latched error never closes a window.
	`QDWD_ASSERT_NOW(a_error_no_close, res_valid && (res_direction == MODE_ERR), !res_closed)

endmodule

bind quadrature_decoder_windowed_delta qdwd_checker #(
	.COUNT_WIDTH(COUNT_WIDTH),
	.TIME_WIDTH (TIME_WIDTH)
) u_qdwd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_direction (result.direction),
	.res_count     (result.position_count),
	.res_closed    (result.window_closed),
	.res_delta     (result.window_delta),
	.res_ticks     (result.window_ticks)
);
